// File: sv/cdq_pkg.sv
`default_nettype none
package cdq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  // fixed field widths
  localparam int REQ_W  = 3;
  localparam int VAL_W  = 32;
  localparam int CAP_W  = 5;
  localparam int FILL_W = 5;

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [VAL_W-1:0] EMPTY_VALUE = {VAL_W{1'b1}};

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_REAR  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_REAR   = 3'd3,
    REQ_QUERY      = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_DONE
  } state_t;

  // zero counts as one, anything above the ring size saturates
  function automatic logic [CNT_W-1:0] active_cap(input logic [CAP_W-1:0] c);
    int cv;
    cv = int'(c);
    if (cv == 0) cv = 1;
    if (cv > DEPTH) cv = DEPTH;
    return CNT_W'(cv);
  endfunction

  function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] i,
                                                 input logic [CNT_W-1:0]  cap);
    logic [CNT_W:0] nxt;
    nxt = (CNT_W + 1)'(i) + (CNT_W + 1)'(1);
    return (nxt >= (CNT_W + 1)'(cap)) ? SLOT_W'(0) : SLOT_W'(nxt);
  endfunction

  function automatic logic [SLOT_W-1:0] wrap_dec(input logic [SLOT_W-1:0] i,
                                                 input logic [CNT_W-1:0]  cap);
    logic [CNT_W:0] wide_i;
    wide_i = (CNT_W + 1)'(i);
    if (i == SLOT_W'(0) || wide_i >= (CNT_W + 1)'(cap)) begin
      return SLOT_W'(cap - CNT_W'(1));
    end
    return i - SLOT_W'(1);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] to_store(input logic [VAL_W-1:0] v);
    logic [DATA_WIDTH+VAL_W-1:0] e;
    e = {{DATA_WIDTH{1'b0}}, v};
    return e[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] to_out(input logic [DATA_WIDTH-1:0] d);
    logic [DATA_WIDTH+VAL_W-1:0] e;
    e = {{VAL_W{1'b0}}, d};
    return e[VAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/circular_deque_core.sv
// circular deque held in a ring of slots in a small synchronous memory
//
// input channel (in_valid/in_ready, req_type, new_value): one request per transfer:
// push front, push rear, pop front, pop rear or query. output channel
// (out_valid/out_ready): one result per request with ok, front and rear value
// (-1 when empty), empty and full flags and the fill level after the request.
// config channel (cfg_valid/cfg_ready, cfg_data): writes the capacity and
// clears the queue; only taken between requests.
//
// a request runs through the execute, read and done states: the execute state
// updates the pointers and writes the pushed slot, the read state reads the front
// and rear slots, and the done state loads the registered read data into the output
// register. a new request is taken only once the previous one has loaded its result.
// a stalled receiver holds the result in the output register; the next request
// is still accepted and runs up to the point of loading its result, then waits.
// reset: capacity 16, queue empty; slot contents are undefined until pushed.
`default_nettype none
module circular_deque_core
  import cdq_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire  [CAP_W-1:0]        cfg_data,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [REQ_W-1:0]        req_type,
  input  wire  signed [VAL_W-1:0] new_value,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic                    ok,
  output logic signed [VAL_W-1:0] front_value,
  output logic signed [VAL_W-1:0] rear_value,
  output logic                    is_empty,
  output logic                    is_full,
  output logic [FILL_W-1:0]       fill_level
);

  // slot memory, two read ports and one write port
  logic [DATA_WIDTH-1:0] mem [DEPTH];

  state_t state, state_next;

  // control state
  logic [CAP_W-1:0]  capacity;
  logic [SLOT_W-1:0] front_slot, front_slot_next;
  logic [SLOT_W-1:0] rear_slot, rear_slot_next;
  logic [CNT_W-1:0]  occupancy, occupancy_next;
  logic [CNT_W-1:0]  acap;

  // captured request
  logic [REQ_W-1:0]  req;
  logic [VAL_W-1:0]  value;
  logic              req_ok, req_ok_next;

  // memory access
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic              rd_en;
  logic [DATA_WIDTH-1:0] rd_front, rd_rear;

  logic              load_out;
  logic              cfg_write;
  logic              in_xfer;

  assign acap      = active_cap(capacity);
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_xfer   = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_xfer) state_next = S_EXEC;
      S_EXEC: state_next = S_READ;
      S_READ: state_next = S_DONE;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state decoded controls
  always_comb begin
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    rd_en     = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cfg_ready = 1'b1;
      end
      S_EXEC: ;
      S_READ: rd_en = 1'b1;
      S_DONE: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  // request execution: pointer moves with wrap at the active capacity
  always_comb begin
    front_slot_next = front_slot;
    rear_slot_next  = rear_slot;
    occupancy_next  = occupancy;
    req_ok_next     = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = front_slot;
    unique case (req_t'(req))
      REQ_PUSH_FRONT: begin
        if (occupancy < acap) begin
          mem_we          = (state == S_EXEC);
          mem_waddr       = front_slot;
          front_slot_next = wrap_dec(front_slot, acap);
          occupancy_next  = occupancy + CNT_W'(1);
          req_ok_next     = 1'b1;
        end
      end
      REQ_PUSH_REAR: begin
        if (occupancy < acap) begin
          mem_we         = (state == S_EXEC);
          mem_waddr      = rear_slot;
          rear_slot_next = wrap_inc(rear_slot, acap);
          occupancy_next = occupancy + CNT_W'(1);
          req_ok_next    = 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (occupancy != CNT_W'(0)) begin
          front_slot_next = wrap_inc(front_slot, acap);
          occupancy_next  = occupancy - CNT_W'(1);
          req_ok_next     = 1'b1;
        end
      end
      REQ_POP_REAR: begin
        if (occupancy != CNT_W'(0)) begin
          rear_slot_next = wrap_dec(rear_slot, acap);
          occupancy_next = occupancy - CNT_W'(1);
          req_ok_next    = 1'b1;
        end
      end
      REQ_QUERY: req_ok_next = 1'b1;
      default: req_ok_next = 1'b0; // unknown code: refused, queue untouched
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      capacity   <= CAP_W'(16);
      front_slot <= SLOT_W'(active_cap(CAP_W'(16)) - CNT_W'(1));
      rear_slot  <= '0;
      occupancy  <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        // new capacity clears the queue, slots keep their contents
        capacity   <= cfg_data;
        front_slot <= SLOT_W'(active_cap(cfg_data) - CNT_W'(1));
        rear_slot  <= '0;
        occupancy  <= '0;
      end else if (state == S_EXEC) begin
        front_slot <= front_slot_next;
        rear_slot  <= rear_slot_next;
        occupancy  <= occupancy_next;
      end
    end
  end

  // request capture and outcome
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req   <= req_type;
      value <= new_value;
    end
    if (state == S_EXEC) begin
      req_ok <= req_ok_next;
    end
  end

  // slot memory: write in the execute state, read in the read state after it so the
  // read never overlaps the write of the same request
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= to_store(value);
    end
    if (rd_en) begin
      rd_front <= mem[wrap_inc(front_slot, acap)];
      rd_rear  <= mem[wrap_dec(rear_slot, acap)];
    end
  end

  // output register, loaded while the previous result is gone or leaving
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ok          <= req_ok;
      front_value <= (occupancy == CNT_W'(0)) ? $signed(EMPTY_VALUE)
                                               : $signed(to_out(rd_front));
      rear_value  <= (occupancy == CNT_W'(0)) ? $signed(EMPTY_VALUE)
                                               : $signed(to_out(rd_rear));
      is_empty    <= (occupancy == CNT_W'(0));
      is_full     <= (occupancy == acap);
      fill_level  <= FILL_W'(occupancy);
    end
  end

`ifndef SYNTH
  // fill level never passes the active capacity
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= acap)
    else $error("occupancy above capacity");

  // both pointers stay inside the active ring
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (CNT_W + 1)'(front_slot) < (CNT_W + 1)'(acap) &&
    (CNT_W + 1)'(rear_slot) < (CNT_W + 1)'(acap))
    else $error("slot pointer outside ring");

  // queue state moves only in the execute cycle or on a capacity write
  a_occ_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_EXEC && !cfg_write) |=> $stable(occupancy))
    else $error("occupancy changed outside execute");

  // an accepted request always runs its execute cycle next
  a_exec_follows: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == S_EXEC)
    else $error("request not executed");
`endif

endmodule
`default_nettype wire

// File: dv/circular_deque_checker.sv
`timescale 1ns / 100ps
module circular_deque_checker
  import cdq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [VAL_W-1:0]  new_value,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              ok,
  input  logic [VAL_W-1:0]  front_value,
  input  logic [VAL_W-1:0]  rear_value,
  input  logic              is_empty,
  input  logic              is_full,
  input  logic [FILL_W-1:0] fill_level,
  output int                errors,
  output int                pending,
  output int                checked
);

  typedef struct {
    logic              ok;
    logic [VAL_W-1:0]  front;
    logic [VAL_W-1:0]  rear;
    logic              empty;
    logic              full;
    logic [FILL_W-1:0] fill;
  } deque_view_t;

  // mirror of the deque
  logic [DATA_WIDTH-1:0] ring [DEPTH];
  logic [CAP_W-1:0]      cap_reg;
  int                    head_gap;
  int                    tail_gap;
  int                    held;

  deque_view_t queued_views[$];
  deque_view_t want;
  deque_view_t got;
  int          err_n;
  int          seen_n;

  // zero means one, anything past the ring saturates
  function automatic int slots_in_use(logic [CAP_W-1:0] c);
    int n;
    n = int'(c);
    if (n == 0) n = 1;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  function automatic int ring_next(int i, int n);
    return (i + 1 >= n) ? 0 : i + 1;
  endfunction

  function automatic int ring_prev(int i, int n);
    return (i == 0 || i >= n) ? n - 1 : i - 1;
  endfunction

  function automatic void empty_ring();
    head_gap = slots_in_use(cap_reg) - 1;
    tail_gap = 0;
    held     = 0;
  endfunction

  // applies one request to the mirror and returns the view after it
  function automatic deque_view_t deque_step(logic [REQ_W-1:0] kind,
                                             logic [VAL_W-1:0] val);
    deque_view_t v;
    int          n;
    n    = slots_in_use(cap_reg);
    v.ok = 1'b0;
    case (kind)
      REQ_PUSH_FRONT: if (held < n) begin
        ring[head_gap] = DATA_WIDTH'(val);
        head_gap = ring_prev(head_gap, n);
        held++;
        v.ok = 1'b1;
      end
      REQ_PUSH_REAR: if (held < n) begin
        ring[tail_gap] = DATA_WIDTH'(val);
        tail_gap = ring_next(tail_gap, n);
        held++;
        v.ok = 1'b1;
      end
      REQ_POP_FRONT: if (held != 0) begin
        head_gap = ring_next(head_gap, n);
        held--;
        v.ok = 1'b1;
      end
      REQ_POP_REAR: if (held != 0) begin
        tail_gap = ring_prev(tail_gap, n);
        held--;
        v.ok = 1'b1;
      end
      REQ_QUERY: v.ok = 1'b1;
      default: ;
    endcase
    if (held != 0) begin
      v.front = VAL_W'(ring[ring_next(head_gap, n)]);
      v.rear  = VAL_W'(ring[ring_prev(tail_gap, n)]);
    end else begin
      v.front = EMPTY_VALUE;
      v.rear  = EMPTY_VALUE;
    end
    v.empty = (held == 0);
    v.full  = (held == n);
    v.fill  = FILL_W'(held);
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (ring[i]) ring[i] = '0;
      cap_reg = CAP_W'(DEPTH);
      empty_ring();
      queued_views.delete();
      err_n  = 0;
      seen_n = 0;
    end else begin
      // results leave before new requests can produce theirs
      if (out_valid && out_ready) begin
        got = '{ok, front_value, rear_value, is_empty, is_full, fill_level};
        if (queued_views.size() == 0) begin
          err_n++;
          if (err_n <= 10)
            $display("%t unexpected result transfer: ok=%0b front=%h rear=%h fill=%0d",
                     $realtime, got.ok, got.front, got.rear, got.fill);
        end else begin
          want = queued_views.pop_front();
          seen_n++;
          if (got.ok !== want.ok || got.front !== want.front ||
              got.rear !== want.rear || got.empty !== want.empty ||
              got.full !== want.full || got.fill !== want.fill) begin
            err_n++;
            if (err_n <= 10) begin
              $display("%t result %0d mismatch", $realtime, seen_n);
              $display("  expected ok=%0b front=%h rear=%h empty=%0b full=%0b fill=%0d",
                       want.ok, want.front, want.rear, want.empty, want.full,
                       want.fill);
              $display("  actual   ok=%0b front=%h rear=%h empty=%0b full=%0b fill=%0d",
                       got.ok, got.front, got.rear, got.empty, got.full, got.fill);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        cap_reg = cfg_data;
        empty_ring();
      end
      if (in_valid && in_ready)
        queued_views.push_back(deque_step(req_type, new_value));
    end
    errors  <= err_n;
    pending <= queued_views.size();
    checked <= seen_n;
  end

endmodule

// File: dv/circular_deque_core_tb.sv
`timescale 1ns / 100ps
module circular_deque_core_tb;
  import cdq_pkg::*;

  logic                    clk;
  logic                    rst;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CAP_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [VAL_W-1:0] new_value;
  logic                    out_valid;
  logic                    out_ready;
  logic                    ok;
  logic signed [VAL_W-1:0] front_value;
  logic signed [VAL_W-1:0] rear_value;
  logic                    is_empty;
  logic                    is_full;
  logic [FILL_W-1:0]       fill_level;

  int fail_count;
  int results_waiting;
  int results_checked;

  // idle odds in percent for each side of the data path
  int send_idle_pct;
  int recv_idle_pct;

  int requests_sent;
  int capacity_writes;

  // capacity per segment: zero, one, the full ring and saturated codes included
  logic [CAP_W-1:0] cap_plan [15] = '{5'd16, 5'd31, 5'd3, 5'd0, 5'd9,
                                      5'd2, 5'd20, 5'd1, 5'd15, 5'd5,
                                      5'd16, 5'd8, 5'd4, 5'd11, 5'd13};

  circular_deque_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .new_value   (new_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .front_value (front_value),
    .rear_value  (rear_value),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .fill_level  (fill_level)
  );

  // watches all three channels, keeps the predicted views and compares
  circular_deque_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .new_value   (new_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .front_value (front_value),
    .rear_value  (rear_value),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .fill_level  (fill_level),
    .errors      (fail_count),
    .pending     (results_waiting),
    .checked     (results_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // one request transfer; random gaps before it, valid held until taken
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [VAL_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= kind;
    new_value <= val;
    do @(posedge clk); while (!in_ready);
    if (kind <= REQ_QUERY) requests_sent++;
  endtask

  // sender holds off until every result in flight has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_waiting != 0);
  endtask

  // capacity writes only land on an idle block, each one empties the queue
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity_writes++;
  endtask

  // payloads lean on the sign and all-ones corners
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {1'b0, {(VAL_W-1){1'b1}}};
      3: return {1'b1, {(VAL_W-1){1'b0}}};
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // bursts that mostly fill, mostly drain or mix, so both full and empty
  // edges are reached with wrapped pointers at every capacity
  task automatic run_segment(input int target);
    int               done_n;
    int               burst;
    int               push_pct;
    int               roll;
    logic [REQ_W-1:0] kind;
    done_n = 0;
    while (done_n < target) begin
      burst = $urandom_range(4, 24);
      case ($urandom_range(0, 2))
        0: push_pct = 75;
        1: push_pct = 25;
        default: push_pct = 50;
      endcase
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          kind = REQ_W'($urandom_range(5, 7));
        end else if (roll < 12) begin
          kind = REQ_QUERY;
        end else if ($urandom_range(0, 99) < push_pct) begin
          kind = $urandom_range(0, 1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
        end else begin
          kind = $urandom_range(0, 1) ? REQ_POP_REAR : REQ_POP_FRONT;
        end
        // now and then let the pipeline run completely dry
        if ($urandom_range(0, 99) == 0) wait_drained();
        send_req(kind, pick_value());
        if (kind <= REQ_QUERY) done_n++;
      end
    end
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_valid       <= 1'b0;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    req_type        <= REQ_QUERY;
    new_value       <= '0;
    send_idle_pct   = 29;
    recv_idle_pct   = 81;
    requests_sent   = 0;
    capacity_writes = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset capacity of 16: empty-queue refusals and unknown codes
    send_req(REQ_QUERY, '0);
    send_req(REQ_POP_FRONT, '1);
    send_req(REQ_POP_REAR, '1);
    send_req(REQ_W'(5), '0);
    send_req(REQ_W'(6), '1);
    send_req(REQ_W'(7), 32'h1234_5678);
    // extreme payloads at both ends, including one that looks like the empty marker
    send_req(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
    send_req(REQ_PUSH_REAR, 32'h8000_0000);
    send_req(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
    send_req(REQ_PUSH_REAR, 32'h0000_0000);
    send_req(REQ_W'(7), 32'hDEAD_BEEF);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_POP_REAR, '0);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_POP_REAR, '0);

    // single slot: full after one push, both pops share it
    write_capacity(5'd1);
    send_req(REQ_PUSH_REAR, 32'h5A5A_5A5A);
    send_req(REQ_PUSH_FRONT, 32'h0F0F_0F0F);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_POP_REAR, '0);
    send_req(REQ_PUSH_FRONT, 32'hA5A5_A5A5);

    // capacity code zero behaves as one
    write_capacity(5'd0);
    send_req(REQ_PUSH_FRONT, 32'h0000_0001);
    send_req(REQ_PUSH_REAR, 32'hFFFF_FFFE);

    // three idling mixes, five capacity settings each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 5; seg++) begin
        write_capacity(cap_plan[ph * 5 + seg]);
        run_segment(60);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("covered %0d requests and %0d results over %0d capacity writes",
             requests_sent, results_checked, capacity_writes);
    $display("capacities ranged from one slot to a saturated ring, under three idle mixes");
    if (fail_count == 0 && results_waiting == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
